/* hw/rtl/aipg_pkg.sv */
package aipg_pkg;

   // default pattern periods in milliseconds
   localparam int unsigned PULSE_MS_DEF = 1500;
   localparam int unsigned FLASH_MS_DEF = 500;

   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned TIME_W    = 16;
   localparam int unsigned COLOR_W   = 8;

   // csr register indexes
   localparam logic [REG_IDX_W-1:0] REG_WARN_ON_MS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WARN_OFF_MS   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ALERT_ON_MS   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ALERT_OFF_MS  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WARN_TONE_HZ  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ALERT_TONE_HZ = 3'd5;

   // register reset values
   localparam logic [TIME_W-1:0] WARN_ON_RST    = 16'd200;
   localparam logic [TIME_W-1:0] WARN_OFF_RST   = 16'd800;
   localparam logic [TIME_W-1:0] ALERT_ON_RST   = 16'd100;
   localparam logic [TIME_W-1:0] ALERT_OFF_RST  = 16'd100;
   localparam logic [TIME_W-1:0] WARN_TONE_RST  = 16'd1000;
   localparam logic [TIME_W-1:0] ALERT_TONE_RST = 16'd2000;

   localparam logic [TIME_W-1:0] SINCE_MAX = 16'hFFFF;

   // input operation codes
   localparam logic OP_TICK       = 1'b0;
   localparam logic OP_WRITE_MODE = 1'b1;

   localparam logic [2:0] MODE_VALUE_MAX = 3'd2;

   typedef enum logic [1:0] {
      MODE_AWAKE = 2'd0,
      MODE_WARN  = 2'd1,
      MODE_ALERT = 2'd2
   } mode_type;

   // fixed colors and levels
   localparam logic [COLOR_W-1:0] AWAKE_RED    = 8'd0;
   localparam logic [COLOR_W-1:0] AWAKE_GREEN  = 8'd255;
   localparam logic [COLOR_W-1:0] AWAKE_BLUE   = 8'd0;
   localparam logic [COLOR_W-1:0] AWAKE_BRIGHT = 8'd10;
   localparam logic [COLOR_W-1:0] WARN_RED     = 8'd255;
   localparam logic [COLOR_W-1:0] WARN_GREEN   = 8'd165;
   localparam logic [COLOR_W-1:0] WARN_BLUE    = 8'd0;
   localparam logic [COLOR_W-1:0] ALERT_RED    = 8'd255;
   localparam logic [COLOR_W-1:0] ALERT_GREEN  = 8'd0;
   localparam logic [COLOR_W-1:0] ALERT_BLUE   = 8'd0;
   localparam logic [COLOR_W-1:0] ALERT_BRIGHT = 8'd50;

   // triangle brightness range
   localparam logic [COLOR_W-1:0] BRIGHT_LOW  = 8'd5;
   localparam logic [COLOR_W-1:0] BRIGHT_HIGH = 8'd40;

   typedef struct packed {
      logic                buzzer_on;
      logic [TIME_W-1:0]   tone_hz;
      logic [COLOR_W-1:0]  led_red;
      logic [COLOR_W-1:0]  led_green;
      logic [COLOR_W-1:0]  led_blue;
      logic [COLOR_W-1:0]  led_brightness;
   } rsp_word_type;

endpackage

/* hw/rtl/aipg_if.sv */
interface aipg_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [2:0] mode_value;

   modport source (output valid, output op, output mode_value, input ready);
   modport sink   (input valid, input op, input mode_value, output ready);
endinterface

interface aipg_rsp_if;
   logic        valid;
   logic        ready;
   logic        buzzer_on;
   logic [15:0] tone_hz;
   logic [7:0]  led_red;
   logic [7:0]  led_green;
   logic [7:0]  led_blue;
   logic [7:0]  led_brightness;

   modport source (output valid, output buzzer_on, output tone_hz, output led_red,
                   output led_green, output led_blue, output led_brightness,
                   input ready);
   modport sink   (input valid, input buzzer_on, input tone_hz, input led_red,
                   input led_green, input led_blue, input led_brightness,
                   output ready);
endinterface

interface aipg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/aipg_bright.sv */
module aipg_bright
   import aipg_pkg::*;
#(
   parameter int unsigned PULSE_MS = PULSE_MS_DEF
) (
   input  logic [$clog2(PULSE_MS)-1:0] phase,
   output logic [COLOR_W-1:0]          bright
);

   localparam int unsigned PW         = $clog2(PULSE_MS);
   localparam int unsigned PULSE_HALF = PULSE_MS / 2;
   localparam int unsigned PULSE_REST = PULSE_MS - PULSE_HALF;
   localparam int unsigned SHIFT      = 27;
   localparam int unsigned NUM_W      = 17;
   localparam int unsigned RECIP_W    = 28;
   localparam int unsigned PROD_W     = NUM_W + RECIP_W;
   localparam int unsigned Q_W        = 6;

   // ceil(2^SHIFT / d): exact floor division for numerators below 2^17
   localparam logic [RECIP_W-1:0] RECIP_RISE =
      RECIP_W'(((64'd1 << SHIFT) + 64'(PULSE_HALF) - 64'd1) / 64'(PULSE_HALF));
   localparam logic [RECIP_W-1:0] RECIP_FALL =
      RECIP_W'(((64'd1 << SHIFT) + 64'(PULSE_REST) - 64'd1) / 64'(PULSE_REST));

   logic              rising;
   logic [PW-1:0]     offset;
   logic [NUM_W-1:0]  offset_ext;
   logic [NUM_W-1:0]  num;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    quot;

   always_comb begin
      rising = phase < PW'(PULSE_HALF);
      offset = rising ? phase : phase - PW'(PULSE_HALF);
      offset_ext = NUM_W'(offset);
      // times 35 as 32 + 2 + 1
      num = (offset_ext << 5) + (offset_ext << 1) + offset_ext;
      recip = rising ? RECIP_RISE : RECIP_FALL;
      prod = PROD_W'(num) * PROD_W'(recip);
      quot = prod[SHIFT +: Q_W];
      bright = rising ? BRIGHT_LOW + COLOR_W'(quot) : BRIGHT_HIGH - COLOR_W'(quot);
   end

endmodule

/* hw/rtl/aipg_out_skid.sv */
module aipg_out_skid
   import aipg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_word_type  push_word,
   output logic          can_push,
   aipg_rsp_if.source    rsp
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         pop;

   assign pop      = out_valid_ff & rsp.ready;
   assign can_push = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_word_in  = push_word;
            out_valid_in = 1'b1;
         end else begin
            skid_word_in  = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.buzzer_on      = out_word_ff.buzzer_on;
   assign rsp.tone_hz        = out_word_ff.tone_hz;
   assign rsp.led_red        = out_word_ff.led_red;
   assign rsp.led_green      = out_word_ff.led_green;
   assign rsp.led_blue       = out_word_ff.led_blue;
   assign rsp.led_brightness = out_word_ff.led_brightness;

endmodule

/* hw/rtl/alert_indicator_pattern_generator_core.sv */
// an accepted word's result is registered in the output stage before it shows on rsp_chan
// throughput: one word per cycle, sustained while the consumer keeps rsp ready high
// a two-entry output stage lets one more word in while a result waits to be taken
// reset (synchronous, active high) returns to awake mode, buzzer silent, all
// counters and phases at zero and the timing/tone registers at their defaults
module alert_indicator_pattern_generator_core
   import aipg_pkg::*;
#(
   parameter int unsigned PULSE_MS = PULSE_MS_DEF,
   parameter int unsigned FLASH_MS = FLASH_MS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   aipg_req_if.sink   req_chan,
   aipg_rsp_if.source rsp_chan,
   aipg_csr_if.sink   csr_chan
);

   localparam int unsigned PW = $clog2(PULSE_MS);
   localparam int unsigned FW = $clog2(FLASH_MS);

   logic [TIME_W-1:0] warn_on_ff, warn_off_ff, alert_on_ff, alert_off_ff;
   logic [TIME_W-1:0] warn_tone_ff, alert_tone_ff;

   mode_type          mode_ff, mode_in;
   logic              beep_ff, beep_in;
   logic [TIME_W-1:0] tone_ff, tone_in;
   logic [TIME_W-1:0] since_ff, since_in;
   logic [PW-1:0]     pulse_ff, pulse_in;
   logic [FW-1:0]     flash_ff, flash_in;

   logic              push;
   logic              can_push;
   logic              tick;
   logic [TIME_W-1:0] since_t;
   logic [TIME_W-1:0] on_sel, off_sel, tone_sel;
   logic [COLOR_W-1:0] tri_bright;
   rsp_word_type      word;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = can_push;
   assign push = req_chan.valid & can_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_on_ff    <= WARN_ON_RST;
         warn_off_ff   <= WARN_OFF_RST;
         alert_on_ff   <= ALERT_ON_RST;
         alert_off_ff  <= ALERT_OFF_RST;
         warn_tone_ff  <= WARN_TONE_RST;
         alert_tone_ff <= ALERT_TONE_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_WARN_ON_MS:    warn_on_ff    <= csr_chan.data;
            REG_WARN_OFF_MS:   warn_off_ff   <= csr_chan.data;
            REG_ALERT_ON_MS:   alert_on_ff   <= csr_chan.data;
            REG_ALERT_OFF_MS:  alert_off_ff  <= csr_chan.data;
            REG_WARN_TONE_HZ:  warn_tone_ff  <= csr_chan.data;
            REG_ALERT_TONE_HZ: alert_tone_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      tick = req_chan.op == OP_TICK;

      since_t  = (tick && since_ff != SINCE_MAX) ? since_ff + 16'd1 : since_ff;
      pulse_in = pulse_ff;
      flash_in = flash_ff;
      mode_in  = mode_ff;
      if (tick) begin
         pulse_in = (pulse_ff == PW'(PULSE_MS - 1)) ? '0 : pulse_ff + PW'(1);
         flash_in = (flash_ff == FW'(FLASH_MS - 1)) ? '0 : flash_ff + FW'(1);
      end else if (req_chan.mode_value <= MODE_VALUE_MAX) begin
         mode_in = mode_type'(req_chan.mode_value[1:0]);
      end

      if (mode_in == MODE_WARN) begin
         on_sel   = warn_on_ff;
         off_sel  = warn_off_ff;
         tone_sel = warn_tone_ff;
      end else begin
         on_sel   = alert_on_ff;
         off_sel  = alert_off_ff;
         tone_sel = alert_tone_ff;
      end

      beep_in  = beep_ff;
      tone_in  = tone_ff;
      since_in = since_t;
      if (mode_in == MODE_AWAKE) begin
         beep_in = 1'b0;
         tone_in = '0;
      end else if (beep_ff) begin
         if (since_t >= on_sel) begin
            beep_in  = 1'b0;
            tone_in  = '0;
            since_in = '0;
         end
      end else if (since_t >= off_sel) begin
         beep_in  = 1'b1;
         tone_in  = tone_sel;
         since_in = '0;
      end

      word.buzzer_on = beep_in;
      word.tone_hz   = beep_in ? tone_in : '0;
      case (mode_in)
         MODE_AWAKE: begin
            word.led_red        = AWAKE_RED;
            word.led_green      = AWAKE_GREEN;
            word.led_blue       = AWAKE_BLUE;
            word.led_brightness = AWAKE_BRIGHT;
         end
         MODE_WARN: begin
            word.led_red        = WARN_RED;
            word.led_green      = WARN_GREEN;
            word.led_blue       = WARN_BLUE;
            word.led_brightness = tri_bright;
         end
         default: begin
            // red flash during the first half of the flash period
            if (flash_in < FW'(FLASH_MS / 2)) begin
               word.led_red        = ALERT_RED;
               word.led_green      = ALERT_GREEN;
               word.led_blue       = ALERT_BLUE;
               word.led_brightness = ALERT_BRIGHT;
            end else begin
               word.led_red        = '0;
               word.led_green      = '0;
               word.led_blue       = '0;
               word.led_brightness = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_AWAKE;
         beep_ff  <= 1'b0;
         tone_ff  <= '0;
         since_ff <= '0;
         pulse_ff <= '0;
         flash_ff <= '0;
      end else if (push) begin
         mode_ff  <= mode_in;
         beep_ff  <= beep_in;
         tone_ff  <= tone_in;
         since_ff <= since_in;
         pulse_ff <= pulse_in;
         flash_ff <= flash_in;
      end
   end

   aipg_bright #(
      .PULSE_MS (PULSE_MS)
   ) u_bright (
      .phase  (pulse_in),
      .bright (tri_bright)
   );

   aipg_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (word),
      .can_push  (can_push),
      .rsp       (rsp_chan)
   );

endmodule

/* sim/alert_indicator_pattern_generator_core_tb.sv */
module alert_indicator_pattern_generator_core_tb;
   import aipg_pkg::*;

   localparam int unsigned CLOCK_PERIOD = 12;
   localparam int unsigned RUN_LIMIT    = 1_000_000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned PULSE_LEN    = PULSE_MS_DEF;
   localparam int unsigned FLASH_LEN    = FLASH_MS_DEF;
   localparam int unsigned PULSE_W      = $clog2(PULSE_LEN);
   localparam int unsigned FLASH_W      = $clog2(FLASH_LEN);
   localparam int unsigned RANDOM_SETS  = 5;
   localparam int unsigned SET_WORDS    = 80;
   localparam int unsigned QUIET_TICKS  = 40;

   // indexes past the last register, writes there must change nothing
   localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_ALERT_TONE_HZ + 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_ALERT_TONE_HZ + 3'd2;

   typedef struct {
      logic [TIME_W-1:0] warn_on;
      logic [TIME_W-1:0] warn_off;
      logic [TIME_W-1:0] alert_on;
      logic [TIME_W-1:0] alert_off;
      logic [TIME_W-1:0] warn_tone;
      logic [TIME_W-1:0] alert_tone;
   } timing_regs_type;

   logic clock;
   logic reset;

   aipg_req_if req_chan ();
   aipg_rsp_if rsp_chan ();
   aipg_csr_if csr_chan ();

   alert_indicator_pattern_generator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // indicator state as the block should hold it
   timing_regs_type regs_now = '{WARN_ON_RST, WARN_OFF_RST, ALERT_ON_RST, ALERT_OFF_RST,
                                 WARN_TONE_RST, ALERT_TONE_RST};
   mode_type            mode_now     = MODE_AWAKE;
   logic                beeping      = 1'b0;
   logic [TIME_W-1:0]   beep_tone    = '0;
   logic [TIME_W-1:0]   since_toggle = '0;
   logic [PULSE_W-1:0]  pulse_pos    = '0;
   logic [FLASH_W-1:0]  flash_pos    = '0;

   rsp_word_type expected_words[$];
   int unsigned  mismatches = 0;
   bit           tx_idle    = 1'b1;
   bit           rx_idle    = 1'b1;
   int unsigned  rx_hold    = 0;

   initial clock = 1'b0;
   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   function automatic void toggle_beeper(input logic [TIME_W-1:0] on_ms,
                                         input logic [TIME_W-1:0] off_ms,
                                         input logic [TIME_W-1:0] tone);
      if (beeping) begin
         if (since_toggle >= on_ms) begin
            beeping      = 1'b0;
            beep_tone    = '0;
            since_toggle = '0;
         end
      end else if (since_toggle >= off_ms) begin
         beeping      = 1'b1;
         beep_tone    = tone;
         since_toggle = '0;
      end
   endfunction

   // rises over the first half of the pulse period and falls over the rest
   function automatic logic [COLOR_W-1:0] pulse_level(input int unsigned pos);
      int unsigned half;
      int unsigned span;
      half = PULSE_LEN / 2;
      span = BRIGHT_HIGH - BRIGHT_LOW;
      if (pos < half)
         return COLOR_W'(BRIGHT_LOW + (pos * span) / half);
      return COLOR_W'(BRIGHT_HIGH - ((pos - half) * span) / (PULSE_LEN - half));
   endfunction

   function automatic rsp_word_type advance_indicator(input logic op,
                                                      input logic [2:0] mode_req);
      rsp_word_type w;
      w = '0;
      if (op == OP_TICK) begin
         if (since_toggle != SINCE_MAX)
            since_toggle++;
         pulse_pos = (pulse_pos == PULSE_W'(PULSE_LEN - 1)) ? '0 : pulse_pos + 1'b1;
         flash_pos = (flash_pos == FLASH_W'(FLASH_LEN - 1)) ? '0 : flash_pos + 1'b1;
      end else if (mode_req <= MODE_VALUE_MAX) begin
         mode_now = mode_type'(mode_req[1:0]);
      end
      case (mode_now)
         MODE_AWAKE: begin
            beeping          = 1'b0;
            beep_tone        = '0;
            w.led_red        = AWAKE_RED;
            w.led_green      = AWAKE_GREEN;
            w.led_blue       = AWAKE_BLUE;
            w.led_brightness = AWAKE_BRIGHT;
         end
         MODE_WARN: begin
            toggle_beeper(regs_now.warn_on, regs_now.warn_off, regs_now.warn_tone);
            w.led_red        = WARN_RED;
            w.led_green      = WARN_GREEN;
            w.led_blue       = WARN_BLUE;
            w.led_brightness = pulse_level(pulse_pos);
         end
         default: begin
            toggle_beeper(regs_now.alert_on, regs_now.alert_off, regs_now.alert_tone);
            // second half of the flash period leaves everything dark
            if (flash_pos < FLASH_LEN / 2) begin
               w.led_red        = ALERT_RED;
               w.led_green      = ALERT_GREEN;
               w.led_blue       = ALERT_BLUE;
               w.led_brightness = ALERT_BRIGHT;
            end
         end
      endcase
      w.buzzer_on = beeping;
      w.tone_hz   = beeping ? beep_tone : '0;
      return w;
   endfunction

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("buzzer %b tone %0d rgb %0d/%0d/%0d bright %0d", w.buzzer_on,
                       w.tone_hz, w.led_red, w.led_green, w.led_blue, w.led_brightness);
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.buzzer_on      = rsp_chan.buzzer_on;
         got.tone_hz        = rsp_chan.tone_hz;
         got.led_red        = rsp_chan.led_red;
         got.led_green      = rsp_chan.led_green;
         got.led_blue       = rsp_chan.led_blue;
         got.led_brightness = rsp_chan.led_brightness;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: rsp word with none expected: %s", $time, word_text(got));
         end else begin
            want = expected_words.pop_front();
            if (got.buzzer_on !== want.buzzer_on || got.tone_hz !== want.tone_hz ||
                got.led_red !== want.led_red || got.led_green !== want.led_green ||
                got.led_blue !== want.led_blue ||
                got.led_brightness !== want.led_brightness) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: rsp mismatch\n   expected %s\n   actual   %s", $time,
                           word_text(want), word_text(got));
            end
         end
      end
   end

   // result side: random stalls per word while rx_idle is set, plus a long hold when a test asks
   initial begin : rsp_taker
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (rx_hold != 0) begin
            stall   = rx_hold;
            rx_hold = 0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 6) : 0;
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_word(input logic op, input logic [2:0] mode_req);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.mode_value <= mode_req;
      do @(posedge clock); while (!req_chan.ready);
      expected_words.push_back(advance_indicator(op, mode_req));
   endtask

   task automatic send_mode(input mode_type m);
      send_word(OP_WRITE_MODE, {1'b0, m});
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_word(OP_TICK, 3'($urandom_range(0, 7)));
   endtask

   task automatic send_random_word();
      logic [2:0] mode_req;
      mode_req = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) begin
         // mostly legal modes so the beep and flash patterns get exercised
         if ($urandom_range(0, 3) != 0)
            mode_req = 3'($urandom_range(0, MODE_VALUE_MAX));
         send_word(OP_WRITE_MODE, mode_req);
      end else begin
         send_word(OP_TICK, mode_req);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_WARN_ON_MS:    regs_now.warn_on    = value;
         REG_WARN_OFF_MS:   regs_now.warn_off   = value;
         REG_ALERT_ON_MS:   regs_now.alert_on   = value;
         REG_ALERT_OFF_MS:  regs_now.alert_off  = value;
         REG_WARN_TONE_HZ:  regs_now.warn_tone  = value;
         REG_ALERT_TONE_HZ: regs_now.alert_tone = value;
         default: ;
      endcase
   endtask

   task automatic program_regs(input timing_regs_type r);
      wait_drained();
      write_reg(REG_SPARE_LO, TIME_W'($urandom));
      write_reg(REG_WARN_ON_MS, r.warn_on);
      write_reg(REG_WARN_OFF_MS, r.warn_off);
      write_reg(REG_ALERT_ON_MS, r.alert_on);
      write_reg(REG_ALERT_OFF_MS, r.alert_off);
      write_reg(REG_WARN_TONE_HZ, r.warn_tone);
      write_reg(REG_ALERT_TONE_HZ, r.alert_tone);
      write_reg(REG_SPARE_HI, TIME_W'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic test_awake_after_reset();
      send_ticks(2);
      for (int v = MODE_VALUE_MAX + 1; v < 8; v++)
         send_word(OP_WRITE_MODE, 3'(v));
      send_mode(MODE_AWAKE);
      send_ticks(2);
      wait_drained();
   endtask

   task automatic test_beep_sequencing();
      program_regs('{16'd3, 16'd5, 16'd2, 16'd4, 16'd1234, 16'd4321});
      send_ticks(6);
      // off time already passed while awake, so the beep starts on the write
      send_mode(MODE_WARN);
      send_ticks(1);
      // beep started in warning keeps the warning tone
      send_mode(MODE_ALERT);
      send_ticks(6);
      send_mode(MODE_WARN);
      send_mode(MODE_AWAKE);
      send_ticks(2);
      send_word(OP_WRITE_MODE, MODE_VALUE_MAX + 3'd3);
      send_mode(MODE_ALERT);
      send_ticks(3);
      wait_drained();
   endtask

   task automatic test_zero_times();
      program_regs('{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h0000});
      // every evaluation in warning or alert mode toggles the buzzer
      send_mode(MODE_WARN);
      send_ticks(3);
      send_word(OP_WRITE_MODE, MODE_VALUE_MAX + 3'd4);
      send_mode(MODE_ALERT);
      send_ticks(3);
      send_word(OP_WRITE_MODE, MODE_VALUE_MAX + 3'd1);
      send_mode(MODE_AWAKE);
      wait_drained();
   endtask

   task automatic test_long_off_time();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      program_regs('{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, TIME_W'($urandom),
                     TIME_W'($urandom)});
      send_mode(MODE_AWAKE);
      send_ticks(QUIET_TICKS);
      // largest off time is never reached, the buzzer stays quiet
      send_mode(MODE_WARN);
      send_ticks(2);
      send_mode(MODE_ALERT);
      send_ticks(2);
      wait_drained();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   task automatic test_pattern_sweep();
      tx_idle = 1'b0;
      program_regs('{16'd7, 16'd11, 16'd3, 16'd5, TIME_W'($urandom), TIME_W'($urandom)});
      send_mode(MODE_WARN);
      send_ticks(PULSE_LEN / 2 + 2);
      send_mode(MODE_ALERT);
      send_ticks(FLASH_LEN / 2 + 2);
      wait_drained();
      tx_idle = 1'b1;
   endtask

   task automatic test_output_backpressure();
      tx_idle = 1'b0;
      rx_hold = 40;
      repeat (30) send_random_word();
      wait_drained();
      tx_idle = 1'b1;
   endtask

   task automatic test_random_traffic();
      timing_regs_type r;
      for (int set = 0; set < RANDOM_SETS; set++) begin
         case (set)
            0: r = '{WARN_ON_RST, WARN_OFF_RST, ALERT_ON_RST, ALERT_OFF_RST,
                     WARN_TONE_RST, ALERT_TONE_RST};
            1: r = '{TIME_W'($urandom_range(1, 12)), TIME_W'($urandom_range(1, 12)),
                     TIME_W'($urandom_range(1, 12)), TIME_W'($urandom_range(1, 12)),
                     TIME_W'($urandom), TIME_W'($urandom)};
            2: r = '{TIME_W'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 3)),
                     TIME_W'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 3)),
                     TIME_W'($urandom), TIME_W'($urandom)};
            3: r = '{16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'h0000};
            default: r = '{TIME_W'($urandom_range(0, 40)), TIME_W'($urandom_range(0, 40)),
                           TIME_W'($urandom_range(0, 40)), TIME_W'($urandom_range(0, 40)),
                           TIME_W'($urandom), TIME_W'($urandom)};
         endcase
         program_regs(r);
         tx_idle = (set != 1) && (set != 4);
         rx_idle = (set != 1);
         for (int i = 0; i < SET_WORDS; i++) begin
            if (i == SET_WORDS / 2)
               wait_drained();
            send_random_word();
         end
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_TICK;
      req_chan.mode_value <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= REG_WARN_ON_MS;
      csr_chan.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_awake_after_reset();
      test_beep_sequencing();
      test_zero_times();
      test_long_off_time();
      test_pattern_sweep();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("** alert_indicator_pattern_generator_core: PASSED **");
      end else begin
         $display("** alert_indicator_pattern_generator_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT * CLOCK_PERIOD);
      $display("timeout with %0d rsp words outstanding", expected_words.size());
      $display("** alert_indicator_pattern_generator_core: FAILED **");
      $finish;
   end

endmodule
